>>> hdl/rff_pkg.sv
// ----------------------------------------------------------------------------
// rff_pkg: shared types and constants of the row FIR filter
// Register map codes, field widths, the job descriptor passed from the
// front to the back, and helpers for tap selection and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package rff_pkg;

  // Parameter defaults
  localparam int MAX_TAPS_DEF   = 7;
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 16;

  // Fixed field widths
  localparam int ROW_WIDTH_BITS = 13;
  localparam int TAP_COUNT_BITS = 3;
  localparam int DIVISOR_BITS   = 16;
  localparam int COEF_BITS      = 16;
  localparam int COEFS_LO_BITS  = 64;
  localparam int COEFS_HI_BITS  = 48;
  localparam int ACC_BITS       = 32;
  localparam int OUT_BITS       = 16;
  localparam int IN_BITS        = 16;

  // Configuration port
  localparam int CFG_ADDR_BITS = 6;
  localparam int CFG_DATA_BITS = 64;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    REG_ROW_WIDTH  = 3'd0,
    REG_TAP_COUNT  = 3'd1,
    REG_DIVISOR    = 3'd2,
    REG_COEFS_LOW  = 3'd3,
    REG_COEFS_HIGH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [ROW_WIDTH_BITS-1:0] row_width;
    logic [TAP_COUNT_BITS-1:0] tap_count;
    logic [DIVISOR_BITS-1:0]   divisor;
    logic [COEFS_LO_BITS-1:0]  coefs_low;
    logic [COEFS_HI_BITS-1:0]  coefs_high;
  } cfg_t;

  // One accepted pixel's work: an optional main column, then trailing zeros
  typedef struct packed {
    logic       has_main;
    logic       compute;
    logic [1:0] zeros;
    logic       row_last;
    logic       frame_last;
  } job_ctrl_t;

  // Clamp the programmed tap count to the supported maximum
  function automatic logic [TAP_COUNT_BITS-1:0] sat_taps(
    input logic [TAP_COUNT_BITS-1:0] tc,
    input logic [TAP_COUNT_BITS-1:0] tmax
  );
    return (tc > tmax) ? tmax : tc;
  endfunction

  // Pick tap s out of the packed coefficient registers
  function automatic logic signed [COEF_BITS-1:0] coef_tap(
    input cfg_t                      cfg,
    input logic [TAP_COUNT_BITS-1:0] s
  );
    logic signed [COEF_BITS-1:0] t;
    unique case (s)
      3'd0:    t = cfg.coefs_low[15:0];
      3'd1:    t = cfg.coefs_low[31:16];
      3'd2:    t = cfg.coefs_low[47:32];
      3'd3:    t = cfg.coefs_low[63:48];
      3'd4:    t = cfg.coefs_high[15:0];
      3'd5:    t = cfg.coefs_high[31:16];
      3'd6:    t = cfg.coefs_high[47:32];
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> hdl/row_fir_filter_core.sv
// ----------------------------------------------------------------------------
// row_fir_filter_core: horizontal FIR filter over a raster pixel stream
// Each row is filtered by a mask of up to seven taps, the sum divided by a
// programmable divisor; border columns give zero.
//
//   channel   signals                          direction  moves
//   pixel     pixel_valid/pixel_stall          in         pixel, frame_end
//   result    result_valid/result_stall        out        filtered, flags
//   config    psel/penable/pwrite/paddr/...    in         register access
//
// A column that needs the mask passes in the back end through the serial
// MAC, a radix-2 divide and the output load. Border-only results need
// only the job fetch and the output load.
// The front takes one pixel per cycle while the two-entry job queue has
// room; pixel_stall is high only when that queue is full.
// Synchronous reset restores the register defaults and clears all control
// state; there is no clearing pass. A stalled result holds in the output
// register while the back keeps working on the next job.
// ----------------------------------------------------------------------------
`default_nettype none

module row_fir_filter_core
  import rff_pkg::*;
#(
  parameter int MAX_TAPS   = MAX_TAPS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output      logic [CFG_DATA_BITS-1:0] prdata,
  output      logic                     pready,
  input  wire logic                     pixel_valid,
  output      logic                     pixel_stall,
  input  wire logic [IN_BITS-1:0]       pixel,
  input  wire logic                     frame_end,
  output      logic                     result_valid,
  input  wire logic                     result_stall,
  output      logic [OUT_BITS-1:0]      filtered,
  output      logic                     row_last,
  output      logic                     frame_last
);

  localparam int WD = 2 * (MAX_TAPS / 2) + 1;

  cfg_t                  cfg;
  logic                  accept;
  logic                  push;
  job_ctrl_t             push_job;
  logic [PIXEL_BITS-1:0] push_win [WD];
  logic                  pop;
  job_ctrl_t             head_job;
  logic [PIXEL_BITS-1:0] head_win [WD];
  logic                  full;
  logic                  empty;

  assign pixel_stall = full;
  assign accept      = pixel_valid && !pixel_stall;

  rff_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rff_front #(
    .MAX_TAPS   (MAX_TAPS),
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .pixel     (pixel),
    .frame_end (frame_end),
    .push      (push),
    .job       (push_job),
    .win       (push_win)
  );

  rff_queue #(
    .PIXEL_BITS (PIXEL_BITS),
    .WD         (WD),
    .DEPTH      (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .push_win (push_win),
    .pop      (pop),
    .head_job (head_job),
    .head_win (head_win),
    .full     (full),
    .empty    (empty)
  );

  rff_back #(
    .MAX_TAPS   (MAX_TAPS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .empty        (empty),
    .head_job     (head_job),
    .head_win     (head_win),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered     (filtered),
    .row_last     (row_last),
    .frame_last   (frame_last)
  );

endmodule

`default_nettype wire

>>> hdl/rff_regs.sv
// ----------------------------------------------------------------------------
// rff_regs: configuration register file
// APB-style write and read access to the five filter registers at 8-byte
// spacing. pready is tied high.
// ----------------------------------------------------------------------------
`default_nettype none

module rff_regs
  import rff_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output      logic [CFG_DATA_BITS-1:0] prdata,
  output      logic                     pready,
  output      cfg_t                     cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:3]);

  // Write selected register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width  <= ROW_WIDTH_BITS'(640);
      cfg.tap_count  <= TAP_COUNT_BITS'(3);
      cfg.divisor    <= DIVISOR_BITS'(1);
      cfg.coefs_low  <= '0;
      cfg.coefs_high <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ROW_WIDTH:  cfg.row_width  <= pwdata[ROW_WIDTH_BITS-1:0];
        REG_TAP_COUNT:  cfg.tap_count  <= pwdata[TAP_COUNT_BITS-1:0];
        REG_DIVISOR:    cfg.divisor    <= pwdata[DIVISOR_BITS-1:0];
        REG_COEFS_LOW:  cfg.coefs_low  <= pwdata[COEFS_LO_BITS-1:0];
        REG_COEFS_HIGH: cfg.coefs_high <= pwdata[COEFS_HI_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_ROW_WIDTH:  prdata = CFG_DATA_BITS'(cfg.row_width);
      REG_TAP_COUNT:  prdata = CFG_DATA_BITS'(cfg.tap_count);
      REG_DIVISOR:    prdata = CFG_DATA_BITS'(cfg.divisor);
      REG_COEFS_LOW:  prdata = CFG_DATA_BITS'(cfg.coefs_low);
      REG_COEFS_HIGH: prdata = CFG_DATA_BITS'(cfg.coefs_high);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/rff_front.sv
// ----------------------------------------------------------------------------
// rff_front: pixel intake and column classification
// Keeps the pixel history and column counter, and turns each accepted
// pixel into a job: whether a column is due, whether it needs the MAC,
// and how many trailing border zeros the row end flushes.
// ----------------------------------------------------------------------------
`default_nettype none

module rff_front
  import rff_pkg::*;
#(
  parameter int MAX_TAPS   = MAX_TAPS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire logic                  accept,
  input  wire logic [IN_BITS-1:0]    pixel,
  input  wire logic                  frame_end,
  output      logic                  push,
  output      job_ctrl_t             job,
  output      logic [PIXEL_BITS-1:0] win [2*(MAX_TAPS/2)+1]
);

  localparam int WD = 2 * (MAX_TAPS / 2) + 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = ($clog2(MAX_WIDTH + 1) > ROW_WIDTH_BITS) ?
                      $clog2(MAX_WIDTH + 1) : ROW_WIDTH_BITS;

  logic [PIXEL_BITS-1:0]     hist [WD];
  logic [CW-1:0]             col;
  logic [CW-1:0]             col_next;
  logic [LW-1:0]             w_eff;
  logic [LW-1:0]             col_ext;
  logic [TAP_COUNT_BITS-1:0] taps;
  logic [1:0]                half;
  logic                      last;
  logic                      ge_half;
  logic                      ge_span;

  // Effective row width: zero reads as one, clamp at the maximum
  always_comb begin
    w_eff = LW'(cfg.row_width);
    if (w_eff == '0) begin
      w_eff = LW'(1);
    end else if (w_eff > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end
  end

  assign taps    = sat_taps(cfg.tap_count, TAP_COUNT_BITS'(MAX_TAPS));
  assign half    = taps[2:1];
  assign col_ext = LW'(col);
  assign last    = frame_end || (col_ext + LW'(1) >= w_eff);
  assign ge_half = col_ext >= LW'(half);
  assign ge_span = col_ext >= LW'({half, 1'b0});

  // Classify the pixel
  always_comb begin
    job.row_last   = last;
    job.frame_last = frame_end;
    job.has_main   = ge_half;
    job.compute    = ge_span;
    job.zeros      = 2'd0;
    if (last) begin
      job.zeros = ge_half ? half : col[1:0];
    end
  end

  assign push     = accept && (job.has_main || (job.zeros != 2'd0));
  assign col_next = last ? '0 : col + CW'(1);

  // Window as seen after this pixel, newest first
  always_comb begin
    win[0] = pixel[PIXEL_BITS-1:0];
    for (int i = 1; i < WD; i++) begin
      win[i] = hist[i-1];
    end
  end

  // Advance history and column on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      for (int i = 0; i < WD; i++) begin
        hist[i] <= '0;
      end
    end else if (accept) begin
      col <= col_next;
      for (int i = 0; i < WD; i++) begin
        hist[i] <= win[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rff_queue.sv
// ----------------------------------------------------------------------------
// rff_queue: job queue between front and back
// Small FIFO of job descriptors with their pixel windows.
// ----------------------------------------------------------------------------
`default_nettype none

module rff_queue
  import rff_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int WD         = 2 * (MAX_TAPS_DEF / 2) + 1,
  parameter int DEPTH      = QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire job_ctrl_t             push_job,
  input  wire logic [PIXEL_BITS-1:0] push_win [WD],
  input  wire logic                  pop,
  output      job_ctrl_t             head_job,
  output      logic [PIXEL_BITS-1:0] head_win [WD],
  output      logic                  full,
  output      logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  job_ctrl_t             q_job [DEPTH];
  logic [PIXEL_BITS-1:0] q_win [DEPTH][WD];
  logic [AW-1:0]         wr_ptr;
  logic [AW-1:0]         rd_ptr;
  logic [NW-1:0]         count;

  assign full  = (count == NW'(DEPTH));
  assign empty = (count == '0);

  assign head_job = q_job[rd_ptr];
  always_comb begin
    for (int i = 0; i < WD; i++) begin
      head_win[i] = q_win[rd_ptr][i];
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      q_job[wr_ptr] <= push_job;
      for (int i = 0; i < WD; i++) begin
        q_win[wr_ptr][i] <= push_win[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/rff_back.sv
// ----------------------------------------------------------------------------
// rff_back: column evaluation and result output
// Runs one job at a time: a serial multiply-accumulate over the taps, a
// restoring divide one quotient bit per cycle, then the results into the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rff_back
  import rff_pkg::*;
#(
  parameter int MAX_TAPS   = MAX_TAPS_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire logic                  empty,
  input  wire job_ctrl_t             head_job,
  input  wire logic [PIXEL_BITS-1:0] head_win [2*(MAX_TAPS/2)+1],
  output      logic                  pop,
  output      logic                  result_valid,
  input  wire logic                  result_stall,
  output      logic [OUT_BITS-1:0]   filtered,
  output      logic                  row_last,
  output      logic                  frame_last
);

  localparam int WD  = 2 * (MAX_TAPS / 2) + 1;
  localparam int WIW = (WD > 1) ? $clog2(WD) : 1;
  localparam int DCW = $clog2(ACC_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DIV,
    S_MAIN,
    S_ZERO
  } state_t;

  state_t                    state;
  job_ctrl_t                 jc;
  logic [1:0]                zcnt;
  logic [PIXEL_BITS-1:0]     bwin [WD];
  logic [TAP_COUNT_BITS-1:0] s;
  logic                      prod_v;
  logic [ACC_BITS-1:0]       prod;
  logic [ACC_BITS-1:0]       acc;
  logic [ACC_BITS-1:0]       dvd;
  logic [DIVISOR_BITS-1:0]   rem;
  logic [DCW-1:0]            dcnt;
  logic                      neg;

  logic [TAP_COUNT_BITS-1:0] taps;
  logic [1:0]                half;
  logic [2:0]                d;
  logic signed [COEF_BITS-1:0]  tap_v;
  logic signed [PIXEL_BITS-1:0] win_v;
  logic [DIVISOR_BITS-1:0]   div_eff;
  logic [DIVISOR_BITS:0]     rem_sh;
  logic                      q_bit;
  logic [ACC_BITS-1:0]       q_fix;
  logic signed [PIXEL_BITS-1:0] q_tr;
  logic [OUT_BITS-1:0]       main_val;
  logic                      slot_free;
  logic                      load;

  assign taps    = sat_taps(cfg.tap_count, TAP_COUNT_BITS'(MAX_TAPS));
  assign half    = taps[2:1];
  assign d       = {half, 1'b0} - s;
  assign tap_v   = coef_tap(cfg, s);
  assign win_v   = bwin[d[WIW-1:0]];
  assign div_eff = (cfg.divisor == '0) ? DIVISOR_BITS'(1) : cfg.divisor;

  // Restoring divide step
  assign rem_sh = {rem, dvd[ACC_BITS-1]};
  assign q_bit  = rem_sh >= {1'b0, div_eff};

  // Quotient sign fix and narrowing to pixel width
  assign q_fix    = neg ? (~dvd + ACC_BITS'(1)) : dvd;
  assign q_tr     = q_fix[PIXEL_BITS-1:0];
  assign main_val = OUT_BITS'(q_tr);

  assign slot_free = !result_valid || !result_stall;
  assign load      = slot_free && ((state == S_MAIN) || (state == S_ZERO));
  assign pop       = (state == S_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      prod_v       <= 1'b0;
    end else begin
      // Raise the output on a load, drop it once taken
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            jc   <= head_job;
            zcnt <= head_job.zeros;
            for (int i = 0; i < WD; i++) begin
              bwin[i] <= head_win[i];
            end
            s      <= '0;
            acc    <= '0;
            prod_v <= 1'b0;
            dvd    <= '0;
            neg    <= 1'b0;
            if (head_job.has_main && head_job.compute) begin
              state <= S_MAC;
            end else if (head_job.has_main) begin
              state <= S_MAIN;
            end else begin
              state <= S_ZERO;
            end
          end
        end

        // One product per cycle, summed in the next cycle
        S_MAC: begin
          acc <= acc + (prod_v ? prod : '0);
          if (s < taps) begin
            prod   <= ACC_BITS'(tap_v * win_v);
            prod_v <= 1'b1;
            s      <= s + TAP_COUNT_BITS'(1);
          end else begin
            prod_v <= 1'b0;
            if (!prod_v) begin
              neg   <= acc[ACC_BITS-1];
              dvd   <= acc[ACC_BITS-1] ? (~acc + ACC_BITS'(1)) : acc;
              rem   <= '0;
              dcnt  <= '0;
              state <= S_DIV;
            end
          end
        end

        // One quotient bit per cycle, quotient shifts into dvd
        S_DIV: begin
          rem  <= q_bit ? DIVISOR_BITS'(rem_sh - {1'b0, div_eff})
                        : rem_sh[DIVISOR_BITS-1:0];
          dvd  <= {dvd[ACC_BITS-2:0], q_bit};
          dcnt <= dcnt + DCW'(1);
          if (dcnt == DCW'(ACC_BITS - 1)) begin
            state <= S_MAIN;
          end
        end

        // Emit the column result
        S_MAIN: begin
          if (slot_free) begin
            filtered     <= main_val;
            row_last     <= (zcnt == 2'd0) && jc.row_last;
            frame_last   <= (zcnt == 2'd0) && jc.frame_last;
            state        <= (zcnt == 2'd0) ? S_IDLE : S_ZERO;
          end
        end

        // Flush trailing border zeros
        S_ZERO: begin
          if (slot_free) begin
            filtered     <= '0;
            row_last     <= (zcnt == 2'd1) && jc.row_last;
            frame_last   <= (zcnt == 2'd1) && jc.frame_last;
            zcnt         <= zcnt - 2'd1;
            if (zcnt == 2'd1) begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
